FILE: hdl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbps_pkg;

    // Pattern store and window geometry
    localparam int MAX_PATTERN_BYTES = 32;
    localparam int PAT_SLOTS         = 32;
    localparam int IDX_W             = $clog2(PAT_SLOTS);
    localparam int LEN_W             = 6;
    localparam int OFFSET_BITS       = 32;
    localparam int ADDR_W            = 64;
    localparam int DATA_W            = 64;
    localparam int PADDR_W           = 6;
    localparam int REG_IDX_W         = 3;

    // Largest usable length, the smaller of the store and the cap
    localparam int LEN_CAP = (MAX_PATTERN_BYTES < PAT_SLOTS) ? MAX_PATTERN_BYTES : PAT_SLOTS;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CARE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BASE = 3'd6;

    typedef logic [IDX_W-1:0] t_idx;

    // Settings every cell needs for its compare
    typedef struct packed {
        logic [PAT_SLOTS-1:0][7:0] pattern;
        logic [PAT_SLOTS-1:0]      care;
        t_idx                      len_m1;
    } t_match_cfg;

    // Full configuration seen by the datapath
    typedef struct packed {
        t_match_cfg        match;
        logic [ADDR_W-1:0] base;
    } t_cfg;

    // Per-cycle control for the cell row
    typedef struct packed {
        logic shift;
        logic clr;
    } t_cell_ctl;

endpackage

FILE: hdl/wildcard_byte_pattern_scan_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_top
// Path: an accepted byte shifts into the cell row and its word is held in the
// cell stage until the output register is free to register its result word.
// Throughput: one byte per cycle while the output is not stalled; the row of
// window cells shifts once per accepted byte and the match is one AND over all cell compares.
// Reset: synchronous, active low; clears the window fill bits, byte count,
// match flag and output valid, and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_top
    import wbps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [ADDR_W-1:0]  o_match_address
);

    t_cfg                   w_cfg;
    t_cell_ctl              w_ctl;
    logic [PAT_SLOTS-1:0]   w_cell_valid;
    logic [PAT_SLOTS-1:0]   w_cell_ok;
    logic [PAT_SLOTS-1:0][7:0] w_cell_byte;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [OFFSET_BITS-1:0] r_count;
    logic [OFFSET_BITS-1:0] n_count;
    logic [OFFSET_BITS-1:0] w_count_base;
    logic                   r_match_done;
    logic                   r_out_valid;
    logic                   r_found;
    logic [ADDR_W-1:0]      r_match_address;

    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_commit;
    logic                   w_hit;
    logic                   w_emit;
    logic                   w_emit_found;
    logic [LEN_W-1:0]       w_len;
    logic [OFFSET_BITS-1:0] w_offset;
    logic [ADDR_W-1:0]      w_addr;

    // Register file
    wbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: the held word leaves when the output register can take it
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_s1_valid & ~w_out_free;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_commit   = r_s1_valid & w_out_free;

    assign w_ctl.shift = w_accept;
    assign w_ctl.clr   = w_commit & r_s1_last;

    // Row of window cells, newest byte in cell 0
    for (genvar k = 0; k < PAT_SLOTS; k++) begin : g_cell
        logic [7:0] w_in_byte;
        logic       w_in_valid;
        if (k == 0) begin : g_head
            assign w_in_byte  = i_data_byte;
            assign w_in_valid = 1'b1;
        end else begin : g_link
            assign w_in_byte  = w_cell_byte[k-1];
            assign w_in_valid = w_cell_valid[k-1];
        end
        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pos   (IDX_W'(k)),
            .i_cfg   (w_cfg.match),
            .i_byte  (w_in_byte),
            .i_valid (w_in_valid),
            .o_byte  (w_cell_byte[k]),
            .o_valid (w_cell_valid[k]),
            .o_ok    (w_cell_ok[k])
        );
    end

    // Count bytes of the region, saturating
    always_comb begin
        w_count_base = w_ctl.clr ? '0 : r_count;
        if (w_accept && (w_count_base != '1)) begin
            n_count = w_count_base + OFFSET_BITS'(1);
        end else begin
            n_count = w_count_base;
        end
    end

    // Hold the word in the cell stage until it commits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_count    <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_commit) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_last <= i_last_byte;
        end
    end

    // Decide the result of the held word
    assign w_hit        = &w_cell_ok;
    assign w_emit_found = ~r_match_done & w_hit;
    assign w_emit       = ~r_match_done & (w_hit | r_s1_last);
    assign w_len        = LEN_W'(w_cfg.match.len_m1) + LEN_W'(1);
    assign w_offset     = r_count - OFFSET_BITS'(w_len);
    assign w_addr       = w_cfg.base + ADDR_W'(w_offset);

    // Track the first match of the region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_done <= 1'b0;
        end else if (w_commit) begin
            if (r_s1_last) begin
                r_match_done <= 1'b0;
            end else if (w_emit_found) begin
                r_match_done <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && w_emit) begin
            r_found         <= w_emit_found;
            r_match_address <= w_emit_found ? w_addr : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_match_address;

`ifndef SYNTHESIS
    // Fill bits form a run starting at the newest cell
    a_fill_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cell_valid & ~{w_cell_valid[PAT_SLOTS-2:0], 1'b1}) == '0)
        else $error("window fill bits are not contiguous");

    // A held word always has its byte in the newest cell
    a_held_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> w_cell_valid[0])
        else $error("held word without a filled head cell");

    // End of region rearms the match flag
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_s1_last) |=> !r_match_done)
        else $error("match flag survived end of region");

    // End of region leaves at most the next region's first byte in the row
    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_s1_last) |=> $countones(w_cell_valid) <= 1)
        else $error("window not cleared at end of region");
`endif

endmodule

FILE: hdl/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// APB register file: pattern words, care mask, pattern length, region base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_cfg
    import wbps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [3:0][63:0]       r_pattern;
    logic [PAT_SLOTS-1:0]   r_care;
    logic [LEN_W-1:0]       r_len;
    logic [ADDR_W-1:0]      r_base;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:3];
    assign w_wr   = psel & penable & pwrite & pready;

    // Store a written word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_care    <= '1;
            r_len     <= LEN_W'(1);
            r_base    <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: r_pattern[w_idx[1:0]] <= pwdata;
                REG_CARE: r_care <= pwdata[PAT_SLOTS-1:0];
                REG_LEN:  r_len  <= pwdata[LEN_W-1:0];
                REG_BASE: r_base <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (w_idx)
            REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: prdata = r_pattern[w_idx[1:0]];
            REG_CARE: prdata = DATA_W'(r_care);
            REG_LEN:  prdata = DATA_W'(r_len);
            REG_BASE: prdata = r_base;
            default:  prdata = '0;
        endcase
    end

    // Clamp the length: zero acts as one, too large acts as the cap
    always_comb begin
        o_cfg.match.pattern = r_pattern;
        o_cfg.match.care    = r_care;
        o_cfg.base          = r_base;
        priority if (r_len == '0) begin
            o_cfg.match.len_m1 = '0;
        end else if (r_len > LEN_W'(LEN_CAP)) begin
            o_cfg.match.len_m1 = IDX_W'(LEN_CAP - 1);
        end else begin
            o_cfg.match.len_m1 = IDX_W'(r_len - LEN_W'(1));
        end
    end

endmodule

FILE: hdl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One window slot: holds a byte and its fill bit, passes them down the row,
// and checks its byte against the pattern position it lines up with.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_cell
    import wbps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_idx       i_pos,
    input  t_match_cfg i_cfg,
    input  logic [7:0] i_byte,
    input  logic       i_valid,
    output logic [7:0] o_byte,
    output logic       o_valid,
    output logic       o_ok
);

    logic [7:0] r_byte;
    logic       r_valid;
    logic       n_valid;
    logic       w_head;
    t_idx       w_idx;
    logic       w_unused;

    assign w_head = (i_pos == '0);

    // Advance the fill bit; the last word of a region empties the row, but for a new byte shifted into the head
    always_comb begin
        if (i_ctl.shift) begin
            n_valid = i_valid & (w_head | ~i_ctl.clr);
        end else begin
            n_valid = r_valid & ~i_ctl.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Shift the byte along the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    // Slot k lines up with pattern byte len-1-k; slots past the length pass
    assign w_idx    = i_cfg.len_m1 - i_pos;
    assign w_unused = i_pos > i_cfg.len_m1;
    assign o_ok     = w_unused |
                      (r_valid & (~i_cfg.care[w_idx] | (r_byte == i_cfg.pattern[w_idx])));

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule
